[rtl/m5ds_pkg.sv]
`timescale 1ns / 1ps

package m5ds_pkg;

   localparam int SAMPLE_W       = 10;
   localparam int BEST_W         = SAMPLE_W + 1;
   localparam int INDEX_W        = 2;
   localparam int DIR_OUT_W      = 3;
   localparam int GROUP_LEN_DEF  = 5;
   localparam int DIRECTIONS_DEF = 4;

   localparam logic [BEST_W-1:0] MEDIAN_INIT = BEST_W'(1 << SAMPLE_W);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                begin_scan;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  group_median;
      logic [INDEX_W-1:0]   group_index;
      logic                 scan_done;
      logic [DIR_OUT_W-1:0] direction;
   } rsp_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                valid;
      logic                lt;
   } link_type;

   localparam link_type LINK_HEAD = '{value: '0, valid: 1'b0, lt: 1'b0};

endpackage

[rtl/m5ds_chan_if.sv]
`timescale 1ns / 1ps

interface m5ds_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/m5ds_cell.sv]
`timescale 1ns / 1ps

module m5ds_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          clear,
   input  logic [m5ds_pkg::SAMPLE_W-1:0] sample,
   input  m5ds_pkg::link_type            prev,
   output m5ds_pkg::link_type            link,
   output logic [m5ds_pkg::SAMPLE_W-1:0] value_next
);

   logic [m5ds_pkg::SAMPLE_W-1:0] value_ff, value_in;
   logic                          valid_ff, valid_in;
   logic                          eff_valid;
   logic                          lt;

   always_comb begin
      eff_valid = valid_ff & ~clear;
      lt        = ~eff_valid | (sample < value_ff);
      if (prev.lt) begin
         value_in = prev.value;
         valid_in = prev.valid;
      end else if (lt) begin
         value_in = sample;
         valid_in = 1'b1;
      end else begin
         value_in = value_ff;
         valid_in = eff_valid;
      end
      link.value = value_ff;
      link.valid = eff_valid;
      link.lt    = lt;
      value_next = value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
      end
   end

endmodule

[rtl/m5ds_chain.sv]
`timescale 1ns / 1ps

module m5ds_chain #(
   parameter int GROUP_LEN = m5ds_pkg::GROUP_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          clear,
   input  logic [m5ds_pkg::SAMPLE_W-1:0] sample,
   output logic [m5ds_pkg::SAMPLE_W-1:0] median
);

   localparam int MED_IDX = GROUP_LEN - 1 - GROUP_LEN / 2;

   m5ds_pkg::link_type            links [GROUP_LEN];
   logic [m5ds_pkg::SAMPLE_W-1:0] nexts [GROUP_LEN];

   for (genvar i = 0; i < GROUP_LEN; i++) begin : g_cell
      m5ds_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (load),
         .clear      (clear),
         .sample     (sample),
         .prev       ((i == 0) ? m5ds_pkg::LINK_HEAD : links[(i == 0) ? 0 : i - 1]),
         .link       (links[i]),
         .value_next (nexts[i])
      );
   end

   assign median = nexts[MED_IDX];

endmodule

[rtl/median5_direction_select.sv]
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// req_chan  in   valid/ready        sample[9:0], begin_scan
// rsp_chan  out  valid/ready        group_median[9:0], group_index[1:0], scan_done,
//                                   direction[2:0]
// One sample per cycle enters the insertion chain while req_chan.ready is high;
// each cell compares and shifts once. A result appears in the output register the
// cycle after the last sample of a group. req_chan.ready drops only while a result
// waits in the output register and rsp_chan.ready is low.
// Reset is synchronous and clears the counts, the best median and the chain valid bits.

module median5_direction_select #(
   parameter int GROUP_LEN  = m5ds_pkg::GROUP_LEN_DEF,
   parameter int DIRECTIONS = m5ds_pkg::DIRECTIONS_DEF
) (
   input logic        clock,
   input logic        reset,
   m5ds_chan_if.sink   req_chan,
   m5ds_chan_if.source rsp_chan
);

   localparam int SC_W  = $clog2(GROUP_LEN);
   localparam int GC_W  = $clog2(DIRECTIONS);
   localparam int DIR_W = $clog2(DIRECTIONS + 1);
   localparam logic [DIR_W-1:0] NO_DIRECTION = DIR_W'(DIRECTIONS);

   logic [SC_W-1:0]                 scnt_ff, scnt_in, scnt_eff;
   logic [GC_W-1:0]                 gcnt_ff, gcnt_in, gcnt_eff;
   logic [m5ds_pkg::BEST_W-1:0]     best_ff, best_in, best_eff;
   logic [DIR_W-1:0]                bdir_ff, bdir_in, bdir_eff, bdir_upd;
   logic                            rsp_valid_ff, rsp_valid_in;
   m5ds_pkg::rsp_payload_type       rsp_payload_ff, rsp_payload_in;
   logic                            accept, clear, last, done, better;
   logic [m5ds_pkg::SAMPLE_W-1:0]   median;

   m5ds_chain #(.GROUP_LEN(GROUP_LEN)) u_chain (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .clear  (clear),
      .sample (req_chan.payload.sample),
      .median (median)
   );

   assign req_chan.ready   = ~rsp_valid_ff | rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   always_comb begin
      accept   = req_chan.valid & req_chan.ready;
      scnt_eff = req_chan.payload.begin_scan ? '0 : scnt_ff;
      gcnt_eff = req_chan.payload.begin_scan ? '0 : gcnt_ff;
      best_eff = req_chan.payload.begin_scan ? m5ds_pkg::MEDIAN_INIT : best_ff;
      bdir_eff = req_chan.payload.begin_scan ? NO_DIRECTION : bdir_ff;
      clear    = (scnt_eff == '0);
      last     = (scnt_eff == SC_W'(GROUP_LEN - 1));
      done     = (gcnt_eff == GC_W'(DIRECTIONS - 1));
      better   = ({1'b0, median} < best_eff);
      bdir_upd = better ? DIR_W'(gcnt_eff) : bdir_eff;

      scnt_in = scnt_ff;
      gcnt_in = gcnt_ff;
      best_in = best_ff;
      bdir_in = bdir_ff;
      if (accept) begin
         scnt_in = last ? '0 : SC_W'(scnt_eff + 1'b1);
         gcnt_in = gcnt_eff;
         best_in = best_eff;
         bdir_in = bdir_eff;
         if (last) begin
            if (done) begin
               gcnt_in = '0;
               best_in = m5ds_pkg::MEDIAN_INIT;
               bdir_in = NO_DIRECTION;
            end else begin
               gcnt_in = GC_W'(gcnt_eff + 1'b1);
               best_in = better ? {1'b0, median} : best_eff;
               bdir_in = bdir_upd;
            end
         end
      end

      rsp_payload_in.group_median = median;
      rsp_payload_in.group_index  = m5ds_pkg::INDEX_W'(gcnt_eff);
      rsp_payload_in.scan_done    = done;
      rsp_payload_in.direction    = done ? m5ds_pkg::DIR_OUT_W'(bdir_upd) : '0;

      if (accept && last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scnt_ff      <= '0;
         gcnt_ff      <= '0;
         best_ff      <= m5ds_pkg::MEDIAN_INIT;
         bdir_ff      <= NO_DIRECTION;
         rsp_valid_ff <= 1'b0;
      end else begin
         scnt_ff      <= scnt_in;
         gcnt_ff      <= gcnt_in;
         best_ff      <= best_in;
         bdir_ff      <= bdir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

[rtl/m5ds_checker.sv]
`timescale 1ns / 1ps

module m5ds_checker #(
   parameter int DIRECTIONS = m5ds_pkg::DIRECTIONS_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_scan_done,
   input logic [m5ds_pkg::DIR_OUT_W-1:0] rsp_direction
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_dir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_scan_done |-> rsp_direction == '0)
      else $error("direction set on a group that does not end the scan");

   a_dir_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scan_done |-> rsp_direction < m5ds_pkg::DIR_OUT_W'(DIRECTIONS))
      else $error("finished scan without a direction");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output register");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");

endmodule

bind median5_direction_select m5ds_checker #(.DIRECTIONS(DIRECTIONS)) u_m5ds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_scan_done (rsp_chan.payload.scan_done),
   .rsp_direction (rsp_chan.payload.direction)
);
